FILE: rtl/core/ptrenc_pkg.sv
package ptrenc_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned REL_W   = 17;
  localparam int unsigned MASK_W  = 5;
  localparam int unsigned BTN_W   = 3;
  localparam int unsigned FLAGS_W = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_A_W = 8;
  localparam int unsigned SLOTS   = 4;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_ORIGIN_X = 8'd0;
  localparam logic [CFG_A_W-1:0] REG_ORIGIN_Y = 8'd1;

  // wheel step masks
  localparam logic [MASK_W-1:0] MASK_WHEEL_UP = 5'd8;
  localparam logic [MASK_W-1:0] MASK_WHEEL_DN = 5'd16;

  // pointer flag words
  localparam logic [FLAGS_W-1:0] EV_MOVE = 16'h0800;
  localparam logic [FLAGS_W-1:0] EV_B1   = 16'h1000;
  localparam logic [FLAGS_W-1:0] EV_B2   = 16'h2000;
  localparam logic [FLAGS_W-1:0] EV_B3   = 16'h4000;
  localparam logic [FLAGS_W-1:0] EV_B4   = 16'h0280;
  localparam logic [FLAGS_W-1:0] EV_B5   = 16'h0380;
  localparam logic [FLAGS_W-1:0] EV_DOWN = 16'h8000;

  typedef logic [FLAGS_W-1:0] flags_t;
  typedef logic [SLOTS-1:0]   slot_mask_t;

endpackage

FILE: rtl/core/ptrenc_ifs.sv
interface ptrenc_in_if import ptrenc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [MASK_W-1:0]        button_mask;
  logic [STAMP_W-1:0]       time_ms;

  modport source (output valid, pos_x, pos_y, button_mask, time_ms, input ready);
  modport sink   (input valid, pos_x, pos_y, button_mask, time_ms, output ready);
endinterface

interface ptrenc_out_if import ptrenc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FLAGS_W-1:0]       event_flags;
  logic signed [REL_W-1:0]  rel_x;
  logic signed [REL_W-1:0]  rel_y;
  logic [STAMP_W-1:0]       stamp_ms;
  logic                     last;

  modport source (output valid, event_flags, rel_x, rel_y, stamp_ms, last, input ready);
  modport sink   (input valid, event_flags, rel_x, rel_y, stamp_ms, last, output ready);
endinterface

interface ptrenc_cfg_if import ptrenc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_A_W-1:0]       index;
  logic [POS_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pointer_state_to_event_encoder_core.sv
// channel   | dir | payload
// ----------+-----+---------------------------------------------------------
// in_port   | in  | pos_x, pos_y, button_mask, time_ms
// out_port  | out | event_flags, rel_x, rel_y, stamp_ms, last
// cfg_port  | in  | index, data (origin_x at 0, origin_y at 1)
//
// a sample is decoded in the cycle it is accepted into a job register holding
// up to four pending events; the output register drains one event per cycle
// unless out_port stalls, so a sample holds the job register until the single
// output register has taken each event it causes (0 to 4); a sample causing no
// event never holds it. the next sample is taken as the last event goes out.
// rst_n is synchronous, active low; clears origin, stored pointer state and
// all valid flags. stalls on out_port hold the output register and the job.
module pointer_state_to_event_encoder_core
  import ptrenc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ptrenc_in_if.sink    in_port,
  ptrenc_out_if.source out_port,
  ptrenc_cfg_if.sink   cfg_port
);

  // configuration
  logic signed [POS_W-1:0] origin_x_r;
  logic signed [POS_W-1:0] origin_y_r;

  // stored pointer state
  logic signed [REL_W-1:0] prev_x_r;
  logic signed [REL_W-1:0] prev_y_r;
  logic [BTN_W-1:0]        prev_btn_r;

  // job register: pending events of the accepted sample
  logic                    job_v_r;
  slot_mask_t              job_pend_r;
  slot_mask_t              job_pend_nxt;
  flags_t                  job_flags_r [SLOTS];
  logic signed [REL_W-1:0] job_x_r;
  logic signed [REL_W-1:0] job_y_r;
  logic [STAMP_W-1:0]      job_stamp_r;

  // output register
  logic                    out_v_r;
  flags_t                  out_flags_r;
  logic signed [REL_W-1:0] out_x_r;
  logic signed [REL_W-1:0] out_y_r;
  logic [STAMP_W-1:0]      out_stamp_r;
  logic                    out_last_r;

  // decode of the incoming sample
  logic signed [REL_W-1:0] rx;
  logic signed [REL_W-1:0] ry;
  logic [BTN_W-1:0]        btn;
  logic [BTN_W-1:0]        chg;
  logic                    wheel;
  flags_t                  wheel_flags;
  slot_mask_t              new_pend;
  flags_t                  new_flags [SLOTS];

  logic                    in_acc;
  logic                    issue;
  logic [1:0]              sel_idx;
  slot_mask_t              sel_bit;

  assign cfg_port.ready = 1'b1;

  assign rx = {in_port.pos_x[POS_W-1], in_port.pos_x} - {origin_x_r[POS_W-1], origin_x_r};
  assign ry = {in_port.pos_y[POS_W-1], in_port.pos_y} - {origin_y_r[POS_W-1], origin_y_r};
  assign btn = in_port.button_mask[BTN_W-1:0];
  assign chg = btn ^ prev_btn_r;
  assign wheel = (in_port.button_mask == MASK_WHEEL_UP) ||
                 (in_port.button_mask == MASK_WHEEL_DN);
  assign wheel_flags = (in_port.button_mask == MASK_WHEEL_UP) ? EV_B4 : EV_B5;

  // slot order: move, left, bit1 button, bit2 button; wheel uses the first two
  always_comb begin
    if (wheel) begin
      new_pend     = 4'b0011;
      new_flags[0] = wheel_flags | EV_DOWN;
      new_flags[1] = wheel_flags;
      new_flags[2] = EV_B1;
      new_flags[3] = EV_B1;
    end else begin
      new_pend     = {chg[2], chg[1], chg[0], (rx != prev_x_r) || (ry != prev_y_r)};
      new_flags[0] = EV_MOVE;
      new_flags[1] = EV_B1 | (btn[0] ? EV_DOWN : '0);
      new_flags[2] = EV_B3 | (btn[1] ? EV_DOWN : '0);
      new_flags[3] = EV_B2 | (btn[2] ? EV_DOWN : '0);
    end
  end

  // lowest pending slot goes out first
  always_comb begin
    priority if (job_pend_r[0]) begin
      sel_idx = 2'd0;
    end else if (job_pend_r[1]) begin
      sel_idx = 2'd1;
    end else if (job_pend_r[2]) begin
      sel_idx = 2'd2;
    end else begin
      sel_idx = 2'd3;
    end
  end

  assign sel_bit      = slot_mask_t'(1) << sel_idx;
  assign issue        = job_v_r && (!out_v_r || out_port.ready);
  assign job_pend_nxt = job_pend_r & ~sel_bit;

  // job frees up as its final event moves into the output register
  assign in_port.ready = !job_v_r || (issue && (job_pend_nxt == '0));
  assign in_acc        = in_port.valid && in_port.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_port.valid) begin
      if (cfg_port.index == REG_ORIGIN_X) begin
        origin_x_r <= cfg_port.data;
      end else if (cfg_port.index == REG_ORIGIN_Y) begin
        origin_y_r <= cfg_port.data;
      end
    end
  end

  // wheel steps leave the stored state alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      prev_btn_r <= '0;
    end else if (in_acc && !wheel) begin
      prev_x_r   <= rx;
      prev_y_r   <= ry;
      prev_btn_r <= btn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r    <= 1'b0;
      job_pend_r <= '0;
    end else if (in_acc) begin
      // a sample with no events never occupies the job register
      job_v_r    <= (new_pend != '0);
      job_pend_r <= new_pend;
    end else if (issue) begin
      job_v_r    <= (job_pend_nxt != '0);
      job_pend_r <= job_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      job_flags_r <= new_flags;
      job_x_r     <= rx;
      job_y_r     <= ry;
      job_stamp_r <= in_port.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (issue) begin
      out_v_r <= 1'b1;
    end else if (out_port.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_flags_r <= job_flags_r[sel_idx];
      out_x_r     <= job_x_r;
      out_y_r     <= job_y_r;
      out_stamp_r <= job_stamp_r;
      out_last_r  <= (job_pend_nxt == '0);
    end
  end

  assign out_port.valid       = out_v_r;
  assign out_port.event_flags = out_flags_r;
  assign out_port.rel_x       = out_x_r;
  assign out_port.rel_y       = out_y_r;
  assign out_port.stamp_ms    = out_stamp_r;
  assign out_port.last        = out_last_r;

endmodule
